// ===== rtl/sbb_pkg.sv =====
// sbb_pkg: shared types, constants and helpers for the spectrum bin ballistics block.
// No dependencies; used by every module of the block except sbb_fifo.
package sbb_pkg;

  typedef enum logic [2:0] {
    REG_FFT_ORDER     = 3'd0,
    REG_ATTACK_COEFF  = 3'd1,
    REG_RELEASE_COEFF = 3'd2,
    REG_PEAK_DECAY    = 3'd3,
    REG_PEAK_HOLD_EN  = 3'd4,
    REG_MIN_DB        = 3'd5,
    REG_MAX_DB        = 3'd6
  } reg_idx_t;

  localparam logic OP_UPDATE     = 1'b0;
  localparam logic OP_CLEAR_PEAK = 1'b1;

  localparam logic [3:0]         ORDER_LO        = 4'd9;
  localparam logic [3:0]         ORDER_HI        = 4'd14;
  localparam logic signed [15:0] RESET_LEVEL     = -16'sd25600;
  localparam logic [14:0]        LOG_CORR_Q16    = 15'd22713;
  localparam logic signed [19:0] DB_PER_LOG2_Q16 = 20'sd394566;

  typedef struct packed {
    logic [3:0]         fft_order;
    logic [15:0]        attack_coeff;
    logic [15:0]        release_coeff;
    logic [11:0]        peak_decay_step;
    logic               peak_hold_enable;
    logic signed [15:0] min_db;
    logic signed [15:0] max_db;
  } cfg_t;

  typedef struct packed {
    logic               op;
    logic [13:0]        bin;
    logic signed [15:0] raw;
    logic               last;
  } item_t;

  typedef struct packed {
    logic [13:0]        bin;
    logic signed [15:0] raw;
    logic signed [15:0] smooth;
    logic signed [15:0] peak;
    logic               done;
  } result_t;

  function automatic logic signed [15:0] clamp_level(input logic signed [19:0] v,
                                                     input logic signed [15:0] lo,
                                                     input logic signed [15:0] hi);
    logic signed [15:0] r;
    if (v < 20'(lo)) r = lo;
    else if (v > 20'(hi)) r = hi;
    else r = v[15:0];
    return r;
  endfunction

endpackage

// ===== rtl/sbb_fifo.sv =====
// sbb_fifo: small register queue, push/full and pop/empty.
// No package dependency; used between front and back and at the result side.
module sbb_fifo #(
  parameter int W     = 32,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0] mem [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [AW:0]   count;
  logic          do_push, do_pop;

  assign full    = (count == (AW+1)'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == AW'(DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == AW'(DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= (AW+1)'(DEPTH))
    else $error("fifo count overflow");
  assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> !empty)
    else $error("fifo lost a beat");
  assert property (@(posedge clk) disable iff (rst)
    (empty && !push) |=> empty)
    else $error("fifo invented a beat");
endmodule

// ===== rtl/sbb_front.sv =====
// sbb_front: magnitude to clamped dB level, six-stage pipeline with one stall enable.
// Depends on sbb_pkg (cfg_t, item_t, clamp_level, constants).
module sbb_front
  import sbb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        in_valid,
  input  logic        in_op,
  input  logic [13:0] in_bin,
  input  logic [39:0] in_mag,
  input  logic        in_last,
  output logic        in_ready,
  output logic        out_valid,
  output item_t       out_item,
  input  logic        out_ready
);
  logic adv;
  logic [6:1] v;

  // stage payloads
  logic        s1_op, s2_op, s3_op, s4_op, s5_op, s6_op;
  logic [13:0] s1_bin, s2_bin, s3_bin, s4_bin, s5_bin, s6_bin;
  logic        s1_last, s2_last, s3_last, s4_last, s5_last, s6_last;
  logic        s1_nz, s2_nz, s3_nz, s4_nz, s5_nz;
  logic [39:0] s1_mag;
  logic [2:0]  s1_byte;
  logic [5:0]  s2_e, s3_e;
  logic [15:0] s2_x, s3_x;
  logic [14:0] s3_t;
  logic signed [23:0] s4_l;
  logic signed [43:0] s5_prod;
  logic signed [15:0] s6_raw;

  logic [2:0]  byte_idx;
  logic [7:0]  top_byte;
  logic [2:0]  bit_idx;
  logic [5:0]  e_c;
  logic [39:0] norm;
  logic [32:0] sq;
  logic [29:0] corr;
  logic [3:0]  ordc;
  logic signed [6:0]  ex;
  logic signed [23:0] l_c;
  logic signed [43:0] rnd;
  logic signed [15:0] raw_c;

  assign adv       = !v[6] || out_ready;
  assign in_ready  = adv;
  assign out_valid = v[6];
  assign out_item  = '{op: s6_op, bin: s6_bin, raw: s6_raw, last: s6_last};

  always_comb begin
    byte_idx = '0;
    for (int b = 0; b < 5; b++) begin
      if (|in_mag[8*b +: 8]) byte_idx = 3'(b);
    end
    top_byte = 8'(s1_mag >> {s1_byte, 3'b000});
    bit_idx  = '0;
    for (int j = 0; j < 8; j++) begin
      if (top_byte[j]) bit_idx = 3'(j);
    end
    e_c  = {s1_byte, bit_idx};
    norm = s1_mag << (6'd39 - e_c);
    sq   = {17'd0, s2_x} * ({1'b0, 16'hFFFF} + 17'd1 - {1'b0, s2_x});
    corr = s3_t * LOG_CORR_Q16;
    ordc = (cfg.fft_order < ORDER_LO) ? ORDER_LO :
           (cfg.fft_order > ORDER_HI) ? ORDER_HI : cfg.fft_order;
    ex   = $signed({1'b0, s3_e}) - 7'sd15 - $signed({3'b000, ordc});
    l_c  = {{1{ex[6]}}, ex, 16'd0} + $signed({8'd0, s3_x}) + $signed({10'd0, corr[29:16]});
    rnd  = (s5_prod + 44'sd8388608) >>> 24;
    if (s5_op == OP_CLEAR_PEAK) raw_c = '0;
    else if (!s5_nz) raw_c = clamp_level(20'(cfg.min_db), cfg.min_db, cfg.max_db);
    else raw_c = clamp_level(rnd[19:0], cfg.min_db, cfg.max_db);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[5:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_op <= in_op;   s1_bin <= in_bin;   s1_last <= in_last;
      s1_mag <= in_mag; s1_byte <= byte_idx; s1_nz <= |in_mag;

      s2_op <= s1_op; s2_bin <= s1_bin; s2_last <= s1_last; s2_nz <= s1_nz;
      s2_e  <= e_c;   s2_x   <= norm[38:23];

      s3_op <= s2_op; s3_bin <= s2_bin; s3_last <= s2_last; s3_nz <= s2_nz;
      s3_e  <= s2_e;  s3_x   <= s2_x;   s3_t    <= sq[30:16];

      s4_op <= s3_op; s4_bin <= s3_bin; s4_last <= s3_last; s4_nz <= s3_nz;
      s4_l  <= l_c;

      s5_op <= s4_op; s5_bin <= s4_bin; s5_last <= s4_last; s5_nz <= s4_nz;
      s5_prod <= s4_l * DB_PER_LOG2_Q16;

      s6_op <= s5_op; s6_bin <= s5_bin; s6_last <= s5_last; s6_raw <= raw_c;
    end
  end

  assert property (@(posedge clk) disable iff (rst) (v[6] && !out_ready) |=> v[6])
    else $error("front dropped a stalled beat");
  assert property (@(posedge clk) disable iff (rst)
    (v[6] && s6_op == OP_CLEAR_PEAK) |-> (s6_raw == 16'sd0))
    else $error("peak clear carries a level");
  assert property (@(posedge clk) disable iff (rst) !adv |=> $stable(v))
    else $error("front moved while stalled");
endmodule

// ===== rtl/sbb_back.sv =====
// sbb_back: per-bin read-modify-write of smoothed and peak levels, plus reset clearing pass.
// Depends on sbb_pkg (cfg_t, item_t, result_t).
module sbb_back
  import sbb_pkg::*;
#(
  parameter int MAX_BINS = 8193
) (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  output logic    clearing,
  input  logic    in_valid,
  input  item_t   in_item,
  output logic    in_pop,
  output logic    res_valid,
  output result_t res,
  input  logic    res_ready
);
  localparam int AW = $clog2(MAX_BINS);

  logic [31:0] mem [MAX_BINS];
  logic [31:0] rd_word;
  logic [AW-1:0] clr_addr;

  logic        b_valid, b_take, b_fire;
  item_t       b_item;
  logic        fwd;
  logic [31:0] fwd_word;

  logic        b_ok, head_ok;
  logic signed [15:0] s_cur, p_cur, sm_new, pk_new;
  logic signed [16:0] d;
  logic        rising;
  logic [15:0] k;
  logic signed [33:0] prod, shv;
  logic signed [17:0] pd;
  logic        we;
  logic [31:0] wword;

  assign b_ok    = ({1'b0, b_item.bin} < 15'(MAX_BINS));
  assign head_ok = ({1'b0, in_item.bin} < 15'(MAX_BINS));
  assign b_fire  = b_valid && res_ready;
  assign b_take  = !clearing && (!b_valid || b_fire);
  assign in_pop  = b_take && in_valid;
  assign res_valid = b_valid;

  always_comb begin
    s_cur  = fwd ? fwd_word[31:16] : rd_word[31:16];
    p_cur  = fwd ? fwd_word[15:0]  : rd_word[15:0];
    rising = b_item.raw > s_cur;
    k      = rising ? cfg.attack_coeff : cfg.release_coeff;
    d      = 17'(b_item.raw) - 17'(s_cur);
    prod   = 34'(d) * $signed({18'd0, k});
    shv    = (prod + 34'sd32768) >>> 16;
    sm_new = s_cur + shv[15:0];
    pd     = 18'(p_cur) - $signed({6'd0, cfg.peak_decay_step});
    if (!cfg.peak_hold_enable) pk_new = p_cur;
    else if (b_item.raw > p_cur) pk_new = b_item.raw;
    else if (pd < 18'(cfg.min_db)) pk_new = cfg.min_db;
    else pk_new = pd[15:0];

    res.bin = b_item.bin;
    res.raw = b_item.raw;
    if (b_item.op == OP_CLEAR_PEAK) begin
      res.smooth = b_ok ? s_cur : '0;
      res.peak   = b_ok ? cfg.min_db : '0;
      res.done   = 1'b0;
      wword      = {s_cur, cfg.min_db};
    end else begin
      res.smooth = b_ok ? sm_new : '0;
      res.peak   = b_ok ? pk_new : '0;
      res.done   = b_item.last;
      wword      = {sm_new, pk_new};
    end
    we = b_fire && b_ok;
  end

  // stores: smoothed level in the upper half, peak in the lower half
  always_ff @(posedge clk) begin
    if (clearing) mem[clr_addr] <= {RESET_LEVEL, RESET_LEVEL};
    else if (we)  mem[b_item.bin[AW-1:0]] <= wword;
  end

  always_ff @(posedge clk) begin
    if (in_pop) rd_word <= mem[in_item.bin[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
      b_valid  <= 1'b0;
    end else begin
      if (clearing) begin
        if (clr_addr == AW'(MAX_BINS-1)) clearing <= 1'b0;
        clr_addr <= clr_addr + 1'b1;
      end
      if (b_take) b_valid <= in_valid;
    end
  end

  // same bin back to back: the read saw the old word, take the one being written
  always_ff @(posedge clk) begin
    if (in_pop) begin
      b_item   <= in_item;
      fwd      <= we && head_ok && (b_item.bin == in_item.bin);
      fwd_word <= wword;
    end
  end

  assert property (@(posedge clk) disable iff (rst) clearing |-> !b_valid && !in_pop)
    else $error("item moved during clearing pass");
  assert property (@(posedge clk) disable iff (rst) we |-> b_valid && !clearing)
    else $error("store write without a beat");
  assert property (@(posedge clk) disable iff (rst) (b_valid && !res_ready) |=> b_valid)
    else $error("back stage dropped a stalled beat");
endmodule

// ===== rtl/spectrum_bin_ballistics_core.sv =====
// Channel   Handshake        Payload
// input     push / full      op, bin_index, magnitude, frame_last
// result    pop / empty      bin_out, raw_level, smooth_level, peak_level, frame_done
// config    cfg_we           cfg_addr, cfg_wdata
//
// One item per cycle sustained while results are popped. Path: the log pipeline,
// the queue, a store read and a compute/write stage, then the result queue.
// After reset a clearing pass writes every bin; full stays high meanwhile.
// The store read-modify-write is one item per cycle while the result queue has room; same-bin neighbors are forwarded.
// Depends on sbb_pkg, sbb_front, sbb_fifo, sbb_back.
module spectrum_bin_ballistics_core
  import sbb_pkg::*;
#(
  parameter int MAX_BINS = 8193
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_addr,
  input  logic [15:0]        cfg_wdata,
  input  logic               push,
  output logic               full,
  input  logic               op,
  input  logic [13:0]        bin_index,
  input  logic [39:0]        magnitude,
  input  logic               frame_last,
  output logic               empty,
  input  logic               pop,
  output logic [13:0]        bin_out,
  output logic signed [15:0] raw_level,
  output logic signed [15:0] smooth_level,
  output logic signed [15:0] peak_level,
  output logic               frame_done
);
  cfg_t    cfg;
  logic    clearing, f_ready, f_valid, q_full, q_empty, q_pop, r_full, b_valid;
  item_t   f_item, q_item;
  logic [$bits(item_t)-1:0]   q_rdata;
  logic [$bits(result_t)-1:0] r_rdata;
  result_t b_res, r_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{fft_order: 4'd11, attack_coeff: 16'd59475, release_coeff: 16'd11075,
               peak_decay_step: 12'd256, peak_hold_enable: 1'b1,
               min_db: RESET_LEVEL, max_db: 16'sd0};
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_addr))
        REG_FFT_ORDER:     cfg.fft_order        <= cfg_wdata[3:0];
        REG_ATTACK_COEFF:  cfg.attack_coeff     <= cfg_wdata;
        REG_RELEASE_COEFF: cfg.release_coeff    <= cfg_wdata;
        REG_PEAK_DECAY:    cfg.peak_decay_step  <= cfg_wdata[11:0];
        REG_PEAK_HOLD_EN:  cfg.peak_hold_enable <= cfg_wdata[0];
        REG_MIN_DB:        cfg.min_db           <= cfg_wdata;
        REG_MAX_DB:        cfg.max_db           <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign full = clearing || !f_ready;

  sbb_front u_front (
    .clk, .rst, .cfg,
    .in_valid (push && !full),
    .in_op    (op),
    .in_bin   (bin_index),
    .in_mag   (magnitude),
    .in_last  (frame_last),
    .in_ready (f_ready),
    .out_valid(f_valid),
    .out_item (f_item),
    .out_ready(!q_full)
  );

  sbb_fifo #(.W($bits(item_t)), .DEPTH(4)) u_queue (
    .clk, .rst,
    .push (f_valid),
    .wdata(f_item),
    .full (q_full),
    .pop  (q_pop),
    .rdata(q_rdata),
    .empty(q_empty)
  );
  assign q_item = item_t'(q_rdata);

  sbb_back #(.MAX_BINS(MAX_BINS)) u_back (
    .clk, .rst, .cfg,
    .clearing (clearing),
    .in_valid (!q_empty),
    .in_item  (q_item),
    .in_pop   (q_pop),
    .res_valid(b_valid),
    .res      (b_res),
    .res_ready(!r_full)
  );

  sbb_fifo #(.W($bits(result_t)), .DEPTH(2)) u_results (
    .clk, .rst,
    .push (b_valid),
    .wdata(b_res),
    .full (r_full),
    .pop  (pop),
    .rdata(r_rdata),
    .empty(empty)
  );
  assign r_res        = result_t'(r_rdata);
  assign bin_out      = r_res.bin;
  assign raw_level    = r_res.raw;
  assign smooth_level = r_res.smooth;
  assign peak_level   = r_res.peak;
  assign frame_done   = r_res.done;

  assert property (@(posedge clk) disable iff (rst) clearing |-> full)
    else $error("input open during clearing pass");
  assert property (@(posedge clk) disable iff (rst) $fell(clearing) |-> empty)
    else $error("result before clearing pass ended");
  assert property (@(posedge clk) disable iff (rst) (!empty && frame_done) |-> !$isunknown(bin_out))
    else $error("frame end beat without bin");
endmodule

// ===== verif/testbench.sv =====
// Testbench for spectrum_bin_ballistics_core: random and directed bin beats checked
// against a local per-bin level/smoothing/peak predictor. Depends on sbb_pkg and the RTL.
`timescale 1ns / 100ps

module testbench;
  import sbb_pkg::*;

  localparam int NBINS = 8193;
  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE = 40;

  typedef struct {
    logic        op;
    logic [13:0] bin;
    logic [39:0] mag;
    logic        last;
  } bin_beat_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [2:0] cfg_addr = '0;
  logic [15:0] cfg_wdata = '0;
  logic push = 0;
  logic full;
  logic op = 0;
  logic [13:0] bin_index = '0;
  logic [39:0] magnitude = '0;
  logic frame_last = 0;
  logic empty;
  logic pop = 0;
  logic [13:0] bin_out;
  logic signed [15:0] raw_level, smooth_level, peak_level;
  logic frame_done;

  spectrum_bin_ballistics_core u_dut (
    .clk, .rst, .cfg_we, .cfg_addr, .cfg_wdata, .push, .full, .op, .bin_index,
    .magnitude, .frame_last, .empty, .pop, .bin_out, .raw_level, .smooth_level,
    .peak_level, .frame_done
  );

  always #6 clk = ~clk;

  // local copy of configuration and per-bin state
  int order_q = 11, atk_q = 59475, rel_q = 11075, decay_q = 256, hold_q = 1;
  int floor_q = -25600, ceil_q = 0;
  int smooth_mem [NBINS];
  int peak_mem [NBINS];

  bin_beat_t pend_q [$];
  result_t level_q [$];
  int errors = 0;
  int send_idle = 22, recv_idle = 51;
  int stall_req = 0;
  int cycles = 0;

  initial begin
    for (int i = 0; i < NBINS; i++) begin
      smooth_mem[i] = -25600;
      peak_mem[i] = -25600;
    end
  end

  function automatic int clamp_db(int v);
    if (v < floor_q) return floor_q;
    if (v > ceil_q) return ceil_q;
    return v;
  endfunction

  function automatic int db_of_mag(logic [39:0] mag);
    int e, ord;
    longint x, c, l;
    if (mag == 0) return clamp_db(floor_q);
    ord = order_q < 9 ? 9 : (order_q > 14 ? 14 : order_q);
    e = 39;
    while (e > 0 && !mag[e]) e--;
    if (e >= 16) x = longint'((mag >> (e - 16)) & 40'hFFFF);
    else x = longint'((mag << (16 - e)) & 40'hFFFF);
    c = (((x * (65536 - x)) >>> 16) * 22713) >>> 16;
    l = longint'(e - 16 - (ord - 1)) * 65536 + x + c;
    return clamp_db(int'((l * 394566 + (longint'(1) << 23)) >>> 24));
  endfunction

  function automatic void predict_levels(bin_beat_t b);
    result_t r;
    int raw, s, p, sm, pk;
    longint k;
    bit ok;
    ok = b.bin < NBINS;
    raw = 0; sm = 0; pk = 0;
    r.done = 1'b0;
    if (b.op == OP_CLEAR_PEAK) begin
      if (ok) begin
        peak_mem[b.bin] = floor_q;
        sm = smooth_mem[b.bin];
        pk = floor_q;
      end
    end else begin
      raw = db_of_mag(b.mag);
      r.done = b.last;
      if (ok) begin
        s = smooth_mem[b.bin];
        p = peak_mem[b.bin];
        k = (raw > s) ? atk_q : rel_q;
        sm = s + int'((longint'(raw - s) * k + 32768) >>> 16);
        smooth_mem[b.bin] = sm;
        if (hold_q != 0) begin
          if (raw > p) p = raw;
          else begin
            p -= decay_q;
            if (p < floor_q) p = floor_q;
          end
          peak_mem[b.bin] = p;
        end
        pk = p;
      end
    end
    r.bin = b.bin;
    r.raw = raw[15:0];
    r.smooth = sm[15:0];
    r.peak = pk[15:0];
    level_q.push_back(r);
  endfunction

  // driver: offers the head of the pending queue, predicts on acceptance
  always @(posedge clk) begin
    if (push && !full) begin
      predict_levels(pend_q[0]);
      void'(pend_q.pop_front());
    end
    if (!rst && pend_q.size() > 0 && $urandom_range(99) >= send_idle) begin
      push <= 1'b1;
      op <= pend_q[0].op;
      bin_index <= pend_q[0].bin;
      magnitude <= pend_q[0].mag;
      frame_last <= pend_q[0].last;
    end else begin
      push <= 1'b0;
    end
  end

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d (cycle %0d)", what, got, want, cycles);
    errors++;
  endtask

  // monitor: checks each popped beat against the oldest expectation
  int hold_left = 0, stall_seen = 0;
  always @(posedge clk) begin
    result_t w;
    cycles++;
    if (pop && !empty) begin
      if (level_q.size() == 0) begin
        report("unexpected beat bin", bin_out, -1);
      end else begin
        w = level_q.pop_front();
        if (bin_out !== w.bin) report("bin_out", bin_out, w.bin);
        if (raw_level !== w.raw) report("raw_level", raw_level, w.raw);
        if (smooth_level !== w.smooth) report("smooth_level", smooth_level, w.smooth);
        if (peak_level !== w.peak) report("peak_level", peak_level, w.peak);
        if (frame_done !== w.done) report("frame_done", frame_done, w.done);
      end
    end
    if (stall_req != stall_seen) begin
      stall_seen = stall_req;
      hold_left = 700;
    end
    if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL spectrum_bin_ballistics_core");
      $finish;
    end
  end

  task automatic write_reg(reg_idx_t idx, int v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= v[15:0];
    case (idx)
      REG_FFT_ORDER:     order_q = v & 'hF;
      REG_ATTACK_COEFF:  atk_q = v & 'hFFFF;
      REG_RELEASE_COEFF: rel_q = v & 'hFFFF;
      REG_PEAK_DECAY:    decay_q = v & 'hFFF;
      REG_PEAK_HOLD_EN:  hold_q = v & 1;
      REG_MIN_DB:        floor_q = int'(signed'(v[15:0]));
      REG_MAX_DB:        ceil_q = int'(signed'(v[15:0]));
      default: ;
    endcase
  endtask

  task automatic set_all(int ord, int atk, int rel, int dec, int hen, int lo, int hi);
    write_reg(REG_FFT_ORDER, ord);
    write_reg(REG_ATTACK_COEFF, atk);
    write_reg(REG_RELEASE_COEFF, rel);
    write_reg(REG_PEAK_DECAY, dec);
    write_reg(REG_PEAK_HOLD_EN, hen);
    write_reg(REG_MIN_DB, lo);
    write_reg(REG_MAX_DB, hi);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pend_q.size() > 0 || level_q.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic bin_beat_t rand_beat();
    bin_beat_t b;
    b.op = ($urandom_range(9) == 0) ? OP_CLEAR_PEAK : OP_UPDATE;
    case ($urandom_range(9))
      0: b.bin = 14'($urandom_range(16383));
      1: b.bin = 14'(8191 + $urandom_range(2));
      default: b.bin = 14'($urandom_range(15));
    endcase
    case ($urandom_range(7))
      0: b.mag = '0;
      1: b.mag = 40'({$urandom, $urandom});
      default: b.mag = 40'({$urandom, $urandom} >> $urandom_range(39));
    endcase
    b.last = ($urandom_range(7) == 0);
    return b;
  endfunction

  function automatic bin_beat_t mk(logic o, int bn, logic [39:0] m, logic l);
    bin_beat_t b;
    b.op = o; b.bin = 14'(bn); b.mag = m; b.last = l;
    return b;
  endfunction

  initial begin
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    while (full) @(posedge clk);   // clearing pass
    repeat (SETTLE) @(posedge clk);

    // directed beats at reset settings
    pend_q.push_back(mk(OP_UPDATE, 0, 40'h0, 0));
    pend_q.push_back(mk(OP_UPDATE, 0, 40'hFF_FFFF_FFFF, 0));
    pend_q.push_back(mk(OP_UPDATE, 0, 40'h1, 0));
    pend_q.push_back(mk(OP_UPDATE, 0, 40'h1, 1));
    pend_q.push_back(mk(OP_CLEAR_PEAK, 0, 40'h12345, 1));
    pend_q.push_back(mk(OP_UPDATE, 0, 40'h8000_0000, 0));
    pend_q.push_back(mk(OP_UPDATE, 8192, 40'hFF_FFFF_FFFF, 1));
    pend_q.push_back(mk(OP_UPDATE, 8193, 40'h100_0000, 1));
    pend_q.push_back(mk(OP_CLEAR_PEAK, 16383, 40'h0, 1));
    pend_q.push_back(mk(OP_CLEAR_PEAK, 8192, 40'h0, 0));
    pend_q.push_back(mk(OP_UPDATE, 5, 40'h4_0000_0000, 0));
    pend_q.push_back(mk(OP_UPDATE, 5, 40'h10, 0));
    pend_q.push_back(mk(OP_UPDATE, 5, 40'h10, 1));
    wait_drained();

    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0: set_all(9, 65535, 0, 0, 1, -32768, 32767);
        1: set_all(14, 0, 65535, 2560, 1, 0, 32767);
        2: set_all(0, 30000, 9000, 4095, 0, -20000, 0);
        3: set_all(15, 1000, 60000, 128, 1, -32768, -32768);
        4: set_all(12, 59475, 11075, 256, 1, 100, -100);   // floor above ceiling
        5: set_all(10, 65535, 65535, 2560, 1, -25600, 32767);
        default: set_all($urandom_range(15), $urandom_range(65535), $urandom_range(65535),
                         $urandom_range(4095), $urandom_range(1),
                         -$urandom_range(32768), $urandom_range(65535) - 32768);
      endcase
      if (ph == 3) begin
        send_idle = 51; recv_idle = 22;
      end else if (ph == 6) begin
        send_idle = 0; recv_idle = 0;
      end
      if (ph == 4) stall_req++;
      for (int n = 0; n < 170; n++) pend_q.push_back(rand_beat());
      wait_drained();
    end

    if (errors == 0) begin
      $display("PASS spectrum_bin_ballistics_core");
    end else begin
      $display("FAIL spectrum_bin_ballistics_core");
    end
    $finish;
  end

endmodule
